// File: src/mir_pkg.sv
// ----------------------------------------------------------------------------
// mir_pkg: shared types and constants for the MAC to ID registry
// Table geometry, action and status codes, table entry and memory request.
// ----------------------------------------------------------------------------
`default_nettype none

package mir_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int MAC_W   = 48;
  localparam int ID_W    = 8;
  localparam int TYPE_W  = 8;
  localparam int OIDX_W  = 5;

  localparam logic [ID_W-1:0] INVALID_ID_RESET = 8'd255;
  localparam logic [ID_W-1:0] FIRST_ID         = 8'd1;

  typedef enum logic [1:0] {
    ACT_RESOLVE  = 2'd0,
    ACT_REGISTER = 2'd1,
    ACT_FIND     = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] ntype;
  } mir_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    mir_entry_t       wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Low bits of a table position as reported on the result
  function automatic logic [OIDX_W-1:0] out_index(input logic [CNT_W-1:0] p);
    logic [CNT_W+OIDX_W-1:0] w;
    w = {{OIDX_W{1'b0}}, p};
    return w[OIDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/mir_table.sv
// ----------------------------------------------------------------------------
// mir_table: entry storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mir_table
  import mir_pkg::*;
(
  input  wire logic       clk,
  input  wire mem_req_t   mem_req,
  output mir_entry_t      rdata
);

  mir_entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[mem_req.raddr];
  end

endmodule

`default_nettype wire

// File: src/mir_ctrl.sv
// ----------------------------------------------------------------------------
// mir_ctrl: search sequencer and result logic
// Streams table reads through one comparator, then resolves, appends or
// reports, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mir_ctrl
  import mir_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [1:0]        action,
  input  wire logic [MAC_W-1:0]  mac_address,
  input  wire logic [ID_W-1:0]   reported_id,
  input  wire logic [TYPE_W-1:0] node_type,
  input  wire logic              cfg_wr_en,
  input  wire logic [ID_W-1:0]   cfg_wr_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [ID_W-1:0]   node_id,
  output      logic [OIDX_W-1:0] entry_index,
  output      logic              found,
  output      logic [1:0]        status,
  output      mem_req_t          mem_req,
  input  wire mir_entry_t        rdata
);

  state_t state, state_next;

  logic [ID_W-1:0]   invalid_id_code;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [ID_W-1:0]   next_free_id, next_free_id_next;

  logic [1:0]        act_q;
  logic [MAC_W-1:0]  mac_q;
  logic [ID_W-1:0]   rep_q;
  logic [TYPE_W-1:0] type_q;

  logic [CNT_W-1:0]  rd_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              hit;
  logic [IDX_W-1:0]  hit_pos;
  logic [ID_W-1:0]   hit_id;

  logic              accept;
  logic              out_free;
  logic              match;
  logic              scan_more;
  logic              scan_done;
  logic              full;

  logic              res_load;
  logic [ID_W-1:0]   res_id;
  logic [CNT_W-1:0]  res_pos;
  logic              res_found;
  status_t           res_status;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign match     = pend && (rdata.mac == mac_q);
  assign scan_more = (rd_idx < entry_count);
  assign scan_done = match || (!pend && !scan_more);
  assign full      = (entry_count == CNT_W'(TABLE_DEPTH));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (scan_done) state_next = S_DECIDE;
      S_DECIDE: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Result and table update
  always_comb begin
    res_load          = (state == S_DECIDE) && out_free;
    res_id            = '0;
    res_pos           = '0;
    res_found         = 1'b0;
    res_status        = ST_OK;
    entry_count_next  = entry_count;
    next_free_id_next = next_free_id;
    mem_req.we        = 1'b0;
    mem_req.waddr     = entry_count[IDX_W-1:0];
    mem_req.wdata.mac   = mac_q;
    mem_req.wdata.id    = next_free_id;
    mem_req.wdata.ntype = '0;
    mem_req.raddr     = rd_idx[IDX_W-1:0];

    unique case (act_q)
      ACT_RESOLVE: begin
        if (hit) begin
          res_id    = hit_id;
          res_pos   = CNT_W'(hit_pos);
          res_found = 1'b1;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          mem_req.we        = res_load;
          res_id            = next_free_id;
          res_pos           = entry_count;
          next_free_id_next = next_free_id + ID_W'(1);
          entry_count_next  = entry_count + CNT_W'(1);
        end
      end
      ACT_REGISTER: begin
        res_found = hit;
        if (full) begin
          res_status = ST_FULL;
        end else begin
          mem_req.we          = res_load;
          mem_req.wdata.ntype = type_q;
          res_pos             = entry_count;
          entry_count_next    = entry_count + CNT_W'(1);
          if (rep_q == invalid_id_code) begin
            res_id            = next_free_id;
            next_free_id_next = next_free_id + ID_W'(1);
          end else begin
            res_id = rep_q;
          end
          mem_req.wdata.id = res_id;
        end
      end
      default: begin
        // find, and the unused code behaves the same
        if (hit) begin
          res_pos   = CNT_W'(hit_pos);
          res_found = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      invalid_id_code <= INVALID_ID_RESET;
      entry_count     <= '0;
      next_free_id    <= FIRST_ID;
      out_valid       <= 1'b0;
      pend            <= 1'b0;
      hit             <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) invalid_id_code <= cfg_wr_data;

      if (accept) begin
        hit  <= 1'b0;
        pend <= 1'b0;
      end else if (state == S_SCAN) begin
        pend <= scan_more && !match;
        if (match) hit <= 1'b1;
      end

      if (res_load) begin
        out_valid    <= 1'b1;
        entry_count  <= entry_count_next;
        next_free_id <= next_free_id_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, scan counter and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= action;
      mac_q  <= mac_address;
      rep_q  <= reported_id;
      type_q <= node_type;
      rd_idx <= '0;
    end else if (state == S_SCAN && scan_more) begin
      rd_idx   <= rd_idx + CNT_W'(1);
      pend_idx <= rd_idx[IDX_W-1:0];
    end
    if (match && state == S_SCAN) begin
      hit_pos <= pend_idx;
      hit_id  <= rdata.id;
    end
    if (res_load) begin
      node_id     <= res_id;
      entry_index <= out_index(res_pos);
      found       <= res_found;
      status      <= res_status;
    end
  end

endmodule

`default_nettype wire

// File: src/mac_to_id_registry_top.sv
// ----------------------------------------------------------------------------
// mac_to_id_registry_top: MAC address to node ID registry
// Linear search over the entry table, then resolve, register or find.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  request  | in_valid / in_stall  | action, mac_address, reported_id, node_type
//  result   | out_valid/ out_stall | node_id, entry_index, found, status
//  config   | cfg_wr_en            | cfg_wr_data (invalid ID code)
//
//  A request reads the stored entries in order and stops early on a match:
//  one table read per cycle through the single read port and comparator,
//  then a decide/append state, then the result register. The result
//  register holds while out_stall is high; the next request is accepted as
//  soon as the previous one has been loaded there.
//  Synchronous active-high reset returns counts, control and the invalid ID
//  code to their reset values; table contents are not cleared.
`default_nettype none

module mac_to_id_registry_top
  import mir_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [1:0]        action,
  input  wire logic [MAC_W-1:0]  mac_address,
  input  wire logic [ID_W-1:0]   reported_id,
  input  wire logic [TYPE_W-1:0] node_type,
  input  wire logic              cfg_wr_en,
  input  wire logic [ID_W-1:0]   cfg_wr_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [ID_W-1:0]   node_id,
  output      logic [OIDX_W-1:0] entry_index,
  output      logic              found,
  output      logic [1:0]        status
);

  mem_req_t   mem_req;
  mir_entry_t rdata;

  mir_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .mac_address (mac_address),
    .reported_id (reported_id),
    .node_type   (node_type),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .node_id     (node_id),
    .entry_index (entry_index),
    .found       (found),
    .status      (status),
    .mem_req     (mem_req),
    .rdata       (rdata)
  );

  mir_table u_table (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

endmodule

`default_nettype wire
